// ----- rtl/lobm_pkg.sv -----
// Package for the limit order book matcher.
// Holds sizes, request kinds, result codes and sequencer state codes.
// No dependencies.
package lobm_pkg;

  localparam int BookSlotsDef = 32;
  localparam int NumInstrumentsDef = 4;
  localparam int InstTagW = 4;

  localparam logic [1:0] KIND_BUY = 2'd0;
  localparam logic [1:0] KIND_SELL = 2'd1;
  localparam logic [1:0] KIND_CANCEL = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam logic [2:0] EV_EXEC = 3'd0;
  localparam logic [2:0] EV_ADDED = 3'd1;
  localparam logic [2:0] EV_CANCEL_OK = 3'd2;
  localparam logic [2:0] EV_CANCEL_REJ = 3'd3;
  localparam logic [2:0] EV_FULL = 3'd4;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_CSCAN = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_OUT = 3'd4;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] price;
    logic [31:0] count;
    logic [31:0] exec;
    logic [31:0] arrival;
  } slot_t;

endpackage

// ----- rtl/lobm_if.sv -----
// Handshake channels of the limit order book matcher.
// Depends on nothing; request and result item payloads.
interface lobm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] order_ref;
  logic [1:0]  instrument;
  logic [31:0] limit_price;
  logic [31:0] quantity;
  modport source(output valid, kind, order_ref, instrument, limit_price, quantity,
                 input ready);
  modport sink(input valid, kind, order_ref, instrument, limit_price, quantity,
               output ready);
endinterface

interface lobm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [31:0] resting_id;
  logic [31:0] active_id;
  logic [31:0] execution_number;
  logic [31:0] trade_price;
  logic [31:0] trade_count;
  logic        sell_side;
  logic [1:0]  instrument_out;
  logic [31:0] sequence_res;
  logic        last;
  modport source(output valid, event_res, resting_id, active_id, execution_number,
                 trade_price, trade_count, sell_side, instrument_out, sequence_res,
                 last, input ready);
  modport sink(input valid, event_res, resting_id, active_id, execution_number,
               trade_price, trade_count, sell_side, instrument_out, sequence_res,
               last, output ready);
endinterface

// ----- rtl/limit_order_book_matcher.sv -----
// Limit order book matcher: price-time priority matching over a slot memory.
// Depends on lobm_pkg and the channel interfaces in lobm_if.sv.
//
// Usage: requests (buy, sell, cancel) enter on in_ch, results leave on out_ch,
// both valid/ready channels. One request is taken at a time; in_ch.ready is
// high only while the block is idle and no result is pending.
// A new order scans all BOOK_SLOTS slots through one memory read port, one
// slot per cycle, to find the best opposing order; the sequencer then decides
// and hands over the result when the receiver is ready. A buy or sell that
// fills a resting order in full with quantity left scans the book again for
// a further result item; a cancel ends its scan at the first slot holding its
// id. The single slot scan loop sets the pace of the block.
// Each result item is held in an output register until out_ch.ready is seen;
// the sequencer waits there, so a stalled receiver simply stalls the matcher.
// Reset clears the slot valid bits and the event counter; no clearing pass
// over the slot memory is needed.
module limit_order_book_matcher #(
  parameter int BOOK_SLOTS = lobm_pkg::BookSlotsDef,
  parameter int NUM_INSTRUMENTS = lobm_pkg::NumInstrumentsDef
) (
  input logic clk,
  input logic rst_n,
  lobm_in_if.sink in_ch,
  lobm_out_if.source out_ch
);
  import lobm_pkg::*;

  localparam int AW = $clog2(BOOK_SLOTS);
  localparam int CW = $clog2(BOOK_SLOTS + 1);
  localparam logic [CW-1:0] SlotsC = CW'(BOOK_SLOTS);
  localparam logic [4:0] NumInstC = 5'(NUM_INSTRUMENTS);

  slot_t mem [BOOK_SLOTS];
  logic                tag_v_r [BOOK_SLOTS];
  logic                tag_s_r [BOOK_SLOTS];
  logic [InstTagW-1:0] tag_i_r [BOOK_SLOTS];

  logic [2:0]  state_r, state_nxt, after_r, after_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic        p_v_r, p_v_nxt;
  logic [AW-1:0] p_idx_r;
  slot_t       rd_q_r;
  logic        p_tv_r, p_ts_r;
  logic [InstTagW-1:0] p_ti_r;

  logic        req_sell_r, req_sell_nxt;
  logic [31:0] req_id_r, req_price_r, rem_r, rem_nxt;
  logic [1:0]  req_inst_r;

  logic        best_v_r, best_v_nxt;
  logic [AW-1:0] best_idx_r, best_idx_nxt;
  slot_t       best_r, best_nxt;
  logic        free_v_r, free_v_nxt;
  logic [AW-1:0] free_idx_r, free_idx_nxt;

  logic        we;
  logic [AW-1:0] wa;
  slot_t       wd;
  logic        tag_set, tag_clr;
  logic [AW-1:0] tag_idx;

  logic [31:0] seq_r;
  logic        ov_r, ov_nxt, load;
  logic [2:0]  o_ev_nxt, o_ev_r;
  logic [31:0] o_rid_nxt, o_rid_r, o_exn_nxt, o_exn_r, o_pr_nxt, o_pr_r, o_cnt_nxt, o_cnt_r;
  logic        o_sell_nxt, o_sell_r, o_last_nxt, o_last_r;
  logic [1:0]  o_inst_nxt, o_inst_r;

  logic        in_fire, out_fire, want_hit, better, crosses;
  logic [AW-1:0] rd_addr;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && !ov_r;
  assign rd_addr = cnt_r[AW-1:0];

  assign want_hit = p_tv_r && (p_ts_r == !req_sell_r) &&
                    (p_ti_r == InstTagW'(req_inst_r));
  always_comb begin
    if (rd_q_r.price != best_r.price) begin
      better = req_sell_r ? (rd_q_r.price > best_r.price) : (rd_q_r.price < best_r.price);
    end else begin
      better = rd_q_r.arrival < best_r.arrival;
    end
  end
  assign crosses = req_sell_r ? !(best_r.price < req_price_r) : !(req_price_r < best_r.price);

  always_comb begin
    state_nxt = state_r;
    after_nxt = after_r;
    cnt_nxt = cnt_r;
    p_v_nxt = 1'b0;
    req_sell_nxt = req_sell_r;
    rem_nxt = rem_r;
    best_v_nxt = best_v_r;
    best_idx_nxt = best_idx_r;
    best_nxt = best_r;
    free_v_nxt = free_v_r;
    free_idx_nxt = free_idx_r;
    we = 1'b0;
    wa = best_idx_r;
    wd = best_r;
    tag_set = 1'b0;
    tag_clr = 1'b0;
    tag_idx = best_idx_r;
    load = 1'b0;
    o_ev_nxt = EV_EXEC;
    o_rid_nxt = '0;
    o_exn_nxt = '0;
    o_pr_nxt = '0;
    o_cnt_nxt = '0;
    o_sell_nxt = 1'b0;
    o_inst_nxt = '0;
    o_last_nxt = 1'b1;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        best_v_nxt = 1'b0;
        free_v_nxt = 1'b0;
        if (in_fire) begin
          req_sell_nxt = (in_ch.kind == KIND_SELL);
          rem_nxt = in_ch.quantity;
          if (in_ch.kind == KIND_CANCEL) begin
            state_nxt = ST_CSCAN;
          end else if (in_ch.kind != KIND_NONE && in_ch.quantity != '0 &&
                       {3'b000, in_ch.instrument} < NumInstC) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN, ST_CSCAN: begin
        if (cnt_r != SlotsC) begin
          p_v_nxt = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
        if (state_r == ST_SCAN) begin
          if (p_v_r && want_hit && (!best_v_r || better)) begin
            best_v_nxt = 1'b1;
            best_idx_nxt = p_idx_r;
            best_nxt = rd_q_r;
          end
          if (p_v_r && !p_tv_r && !free_v_r) begin
            free_v_nxt = 1'b1;
            free_idx_nxt = p_idx_r;
          end
          if (cnt_r == SlotsC) state_nxt = ST_DECIDE;
        end else begin
          o_rid_nxt = '0;
          if (p_v_r && p_tv_r && rd_q_r.id == req_id_r) begin
            tag_clr = 1'b1;
            tag_idx = p_idx_r;
            load = 1'b1;
            o_ev_nxt = EV_CANCEL_OK;
            o_inst_nxt = p_ti_r[1:0];
            after_nxt = ST_IDLE;
            state_nxt = ST_OUT;
          end else if (cnt_r == SlotsC) begin
            load = 1'b1;
            o_ev_nxt = EV_CANCEL_REJ;
            after_nxt = ST_IDLE;
            state_nxt = ST_OUT;
          end
        end
      end
      ST_DECIDE: begin
        load = 1'b1;
        o_sell_nxt = req_sell_r;
        o_inst_nxt = req_inst_r;
        state_nxt = ST_OUT;
        after_nxt = ST_IDLE;
        if (best_v_r && crosses) begin
          o_ev_nxt = EV_EXEC;
          o_rid_nxt = best_r.id;
          o_exn_nxt = best_r.exec;
          o_pr_nxt = best_r.price;
          if (best_r.count > rem_r) begin
            // Partial fill of the resting order: incoming order is done.
            o_cnt_nxt = rem_r;
            o_last_nxt = 1'b1;
            we = 1'b1;
            wd.count = best_r.count - rem_r;
            wd.exec = best_r.exec + 32'd1;
            rem_nxt = '0;
          end else begin
            o_cnt_nxt = best_r.count;
            o_last_nxt = (best_r.count == rem_r);
            tag_clr = 1'b1;
            rem_nxt = rem_r - best_r.count;
            if (best_r.count != rem_r) after_nxt = ST_SCAN;
          end
        end else begin
          o_pr_nxt = req_price_r;
          o_cnt_nxt = rem_r;
          if (free_v_r) begin
            o_ev_nxt = EV_ADDED;
            we = 1'b1;
            wa = free_idx_r;
            wd.id = req_id_r;
            wd.price = req_price_r;
            wd.count = rem_r;
            wd.exec = 32'd1;
            wd.arrival = seq_r;
            tag_set = 1'b1;
            tag_idx = free_idx_r;
          end else begin
            o_ev_nxt = EV_FULL;
          end
        end
      end
      ST_OUT: begin
        cnt_nxt = '0;
        best_v_nxt = 1'b0;
        free_v_nxt = 1'b0;
        if (out_fire) state_nxt = after_r;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign ov_nxt = load ? 1'b1 : (out_fire ? 1'b0 : ov_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      after_r <= ST_IDLE;
      cnt_r <= '0;
      p_v_r <= 1'b0;
      best_v_r <= 1'b0;
      free_v_r <= 1'b0;
      ov_r <= 1'b0;
      seq_r <= '0;
      for (int i = 0; i < BOOK_SLOTS; i++) tag_v_r[i] <= 1'b0;
    end else begin
      state_r <= state_nxt;
      after_r <= after_nxt;
      cnt_r <= cnt_nxt;
      p_v_r <= p_v_nxt;
      best_v_r <= best_v_nxt;
      free_v_r <= free_v_nxt;
      ov_r <= ov_nxt;
      if (load) seq_r <= seq_r + 32'd1;
      if (tag_set) tag_v_r[tag_idx] <= 1'b1;
      else if (tag_clr) tag_v_r[tag_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_set) begin
      tag_s_r[tag_idx] <= req_sell_r;
      tag_i_r[tag_idx] <= InstTagW'(req_inst_r);
    end
    if (we) mem[wa] <= wd;
    rd_q_r <= mem[rd_addr];
    p_tv_r <= tag_v_r[rd_addr];
    p_ts_r <= tag_s_r[rd_addr];
    p_ti_r <= tag_i_r[rd_addr];
    p_idx_r <= rd_addr;
    best_idx_r <= best_idx_nxt;
    best_r <= best_nxt;
    free_idx_r <= free_idx_nxt;
    req_sell_r <= req_sell_nxt;
    rem_r <= rem_nxt;
    if (in_fire) begin
      req_id_r <= in_ch.order_ref;
      req_price_r <= in_ch.limit_price;
      req_inst_r <= in_ch.instrument;
    end
    if (load) begin
      o_ev_r <= o_ev_nxt;
      o_rid_r <= o_rid_nxt;
      o_exn_r <= o_exn_nxt;
      o_pr_r <= o_pr_nxt;
      o_cnt_r <= o_cnt_nxt;
      o_sell_r <= o_sell_nxt;
      o_inst_r <= o_inst_nxt;
      o_last_r <= o_last_nxt;
    end
  end

  logic [31:0] o_seq_r;
  always_ff @(posedge clk) begin
    if (load) o_seq_r <= seq_r;
  end

  assign out_ch.valid = ov_r;
  assign out_ch.event_res = o_ev_r;
  assign out_ch.resting_id = o_rid_r;
  assign out_ch.active_id = req_id_r;
  assign out_ch.execution_number = o_exn_r;
  assign out_ch.trade_price = o_pr_r;
  assign out_ch.trade_count = o_cnt_r;
  assign out_ch.sell_side = o_sell_r;
  assign out_ch.instrument_out = o_inst_r;
  assign out_ch.sequence_res = o_seq_r;
  assign out_ch.last = o_last_r;

`ifndef NO_ASSERTIONS
  a_ready_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid) else $error("request taken with a result pending");
  a_best_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE && best_v_r) |-> tag_v_r[best_idx_r])
    else $error("best slot is not valid");
  a_rescan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_ch.last) |=> state_r == ST_SCAN)
    else $error("no rescan after a partial result");
  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> seq_r == $past(seq_r) + 32'd1) else $error("event counter skipped");
`endif

endmodule

// ----- tb/lobm_tb_if.sv -----
// Testbench copy point for the matcher channel interfaces.
// The channel interfaces themselves live in rtl/lobm_if.sv; this file holds
// a small bundle of item types used by the testbench and depends on lobm_pkg.
package lobm_tb_pkg;
  import lobm_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] order_ref;
    logic [1:0]  instrument;
    logic [31:0] limit_price;
    logic [31:0] quantity;
  } request_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [31:0] resting_id;
    logic [31:0] active_id;
    logic [31:0] execution_number;
    logic [31:0] trade_price;
    logic [31:0] trade_count;
    logic        sell_side;
    logic [1:0]  instrument_out;
    logic [31:0] sequence_res;
    logic        last;
  } report_t;
endpackage

// ----- tb/tb.sv -----
// Self-checking testbench for limit_order_book_matcher.
// Drives requests, predicts the result items with a book model of its own
// and compares them in order. Depends on lobm_pkg, lobm_if.sv, lobm_tb_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lobm_pkg::*;
  import lobm_tb_pkg::*;

  localparam int Slots = BookSlotsDef;
  localparam int WatchLimit = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  lobm_in_if in_ch();
  lobm_out_if out_ch();

  limit_order_book_matcher u_top (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  // Book model
  logic        bk_valid[Slots];
  logic        bk_sell[Slots];
  logic [1:0]  bk_inst[Slots];
  logic [31:0] bk_id[Slots];
  logic [31:0] bk_price[Slots];
  logic [31:0] bk_count[Slots];
  logic [31:0] bk_exec[Slots];
  logic [31:0] bk_arrival[Slots];
  logic [31:0] seq_count;

  report_t expected_reports[$];
  logic [31:0] live_ids[$];
  int errors = 0;
  bit stall_rx = 1'b0;
  bit rx_quiet = 1'b0;
  int idle_cycles = 0;

  function automatic report_t mk(logic [2:0] ev, logic [31:0] rid, logic [31:0] aid,
                                 logic [31:0] exn, logic [31:0] pr, logic [31:0] cnt,
                                 logic sl, logic [1:0] inst, logic lst);
    report_t r;
    r.event_res = ev; r.resting_id = rid; r.active_id = aid; r.execution_number = exn;
    r.trade_price = pr; r.trade_count = cnt; r.sell_side = sl; r.instrument_out = inst;
    r.sequence_res = seq_count; r.last = lst;
    seq_count++;
    return r;
  endfunction

  function automatic int find_best(logic sl, logic [1:0] inst);
    int b;
    logic better;
    b = -1;
    for (int i = 0; i < Slots; i++) begin
      if (!bk_valid[i] || bk_sell[i] == sl || bk_inst[i] != inst) continue;
      if (b < 0) begin
        b = i;
      end else begin
        if (bk_price[i] != bk_price[b])
          better = sl ? (bk_price[i] > bk_price[b]) : (bk_price[i] < bk_price[b]);
        else
          better = bk_arrival[i] < bk_arrival[b];
        if (better) b = i;
      end
    end
    return b;
  endfunction

  task automatic predict_request(request_t rq);
    logic sl;
    logic [31:0] rem;
    logic [31:0] fill;
    int b;
    int n;
    report_t r;
    sl = (rq.kind == KIND_SELL);
    rem = rq.quantity;
    n = 0;
    if (rq.kind == KIND_NONE) return;
    if (rq.kind == KIND_CANCEL) begin
      for (int i = 0; i < Slots; i++) begin
        if (bk_valid[i] && bk_id[i] == rq.order_ref) begin
          bk_valid[i] = 1'b0;
          expected_reports.push_back(mk(EV_CANCEL_OK, '0, rq.order_ref, '0, '0, '0, 1'b0,
                                        bk_inst[i], 1'b1));
          return;
        end
      end
      expected_reports.push_back(mk(EV_CANCEL_REJ, '0, rq.order_ref, '0, '0, '0, 1'b0,
                                    2'd0, 1'b1));
      return;
    end
    if (rem == 0) return;
    while (rem != 0) begin
      b = find_best(sl, rq.instrument);
      if (b < 0) break;
      if (sl ? (bk_price[b] < rq.limit_price) : (rq.limit_price < bk_price[b])) break;
      fill = (bk_count[b] < rem) ? bk_count[b] : rem;
      expected_reports.push_back(mk(EV_EXEC, bk_id[b], rq.order_ref, bk_exec[b], bk_price[b],
                                    fill, sl, rq.instrument, 1'b0));
      n++;
      if (bk_count[b] > rem) begin
        bk_count[b] -= rem;
        bk_exec[b]++;
        rem = 0;
      end else begin
        rem -= bk_count[b];
        bk_valid[b] = 1'b0;
      end
    end
    if (rem == 0) begin
      r = expected_reports.pop_back();
      r.last = 1'b1;
      expected_reports.push_back(r);
      return;
    end
    for (int i = 0; i < Slots; i++) begin
      if (!bk_valid[i]) begin
        bk_valid[i] = 1'b1; bk_sell[i] = sl; bk_inst[i] = rq.instrument;
        bk_id[i] = rq.order_ref; bk_price[i] = rq.limit_price; bk_count[i] = rem;
        bk_exec[i] = 1; bk_arrival[i] = seq_count;
        live_ids.push_back(rq.order_ref);
        expected_reports.push_back(mk(EV_ADDED, '0, rq.order_ref, '0, rq.limit_price, rem, sl,
                                      rq.instrument, 1'b1));
        return;
      end
    end
    expected_reports.push_back(mk(EV_FULL, '0, rq.order_ref, '0, rq.limit_price, rem, sl,
                                  rq.instrument, 1'b1));
  endtask

  function automatic int short_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
  endfunction

  task automatic send_request(request_t rq, bit with_gaps = 1'b1);
    int gap;
    gap = with_gaps ? short_gap() : 0;
    // The previous item ended on a falling edge, so always wait for a fresh one.
    repeat (gap + 1) @(negedge clk);
    in_ch.kind <= rq.kind;
    in_ch.order_ref <= rq.order_ref;
    in_ch.instrument <= rq.instrument;
    in_ch.limit_price <= rq.limit_price;
    in_ch.quantity <= rq.quantity;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_request(rq);
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic send(logic [1:0] k, logic [31:0] id, logic [1:0] inst, logic [31:0] pr,
                      logic [31:0] q);
    request_t rq;
    rq.kind = k; rq.order_ref = id; rq.instrument = inst; rq.limit_price = pr; rq.quantity = q;
    send_request(rq);
  endtask

  task automatic wait_drained();
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (3 * Slots) @(negedge clk);
  endtask

  // Receiver: random ready, steady ready while rx_quiet is set, and long hold-offs when asked.
  always @(negedge clk) begin
    if (!rst_n || stall_rx) out_ch.ready <= 1'b0;
    else if (rx_quiet) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 9) < 7);
  end

  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.event_res = out_ch.event_res; got.resting_id = out_ch.resting_id;
      got.active_id = out_ch.active_id; got.execution_number = out_ch.execution_number;
      got.trade_price = out_ch.trade_price; got.trade_count = out_ch.trade_count;
      got.sell_side = out_ch.sell_side; got.instrument_out = out_ch.instrument_out;
      got.sequence_res = out_ch.sequence_res; got.last = out_ch.last;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result item %p", $realtime, got);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (!in_ch.valid && expected_reports.size() == 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_directed();
    // Book three sell orders, then cross them with buys in partial and full fills, then edge values and cancels.
    send(KIND_SELL, 32'h1, 2'd0, 32'd100, 32'd10);
    send(KIND_SELL, 32'h2, 2'd0, 32'd100, 32'd5);
    send(KIND_SELL, 32'h3, 2'd0, 32'd90, 32'd3);
    send(KIND_BUY, 32'h10, 2'd0, 32'd100, 32'd4);
    send(KIND_BUY, 32'h11, 2'd0, 32'd100, 32'd20);
    send(KIND_BUY, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(KIND_SELL, 32'h0, 2'd3, 32'h0, 32'd1);
    send(KIND_SELL, 32'h20, 2'd3, 32'h0, 32'hFFFF_FFFF);
    send(KIND_BUY, 32'h21, 2'd1, 32'd7, 32'd0);
    send(KIND_NONE, 32'h22, 2'd1, 32'd7, 32'd3);
    send(KIND_CANCEL, 32'h11, 2'd2, 32'd0, 32'd0);
    send(KIND_CANCEL, 32'h11, 2'd0, 32'd0, 32'd0);
    send(KIND_CANCEL, 32'hFFFF_FFFF, 2'd0, 32'd0, 32'd0);
    // Duplicate ids; the cancel removes the lower slot.
    send(KIND_BUY, 32'h55, 2'd2, 32'd50, 32'd2);
    send(KIND_BUY, 32'h55, 2'd2, 32'd60, 32'd2);
    send(KIND_CANCEL, 32'h55, 2'd0, 32'd0, 32'd0);
    send(KIND_SELL, 32'h56, 2'd2, 32'd1, 32'd9);
  endtask

  // Send more buy orders than the book has slots, spread over the instruments, then sells on instrument 1.
  task automatic test_book_full();
    for (int i = 0; i < Slots + 2; i++)
      send(KIND_BUY, 32'h100 + i, 2'(i), 32'd10, 32'd1);
    send(KIND_SELL, 32'h200, 2'd1, 32'd5, 32'hFFFF_FFFF);
    send(KIND_SELL, 32'h201, 2'd1, 32'd5, 32'd1);
  endtask

  // Receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    fork
      begin
        stall_rx = 1'b1;
        repeat (400) @(negedge clk);
        stall_rx = 1'b0;
      end
      for (int i = 0; i < 6; i++)
        send(i[0] ? KIND_SELL : KIND_BUY, 32'h300 + i, 2'd0, 32'd50, 32'd2);
    join
    wait_drained();
  endtask

  task automatic test_random();
    request_t rq;
    int pick;
    for (int n = 0; n < 55; n++) begin
      pick = $urandom_range(0, 99);
      rq.order_ref = $urandom();
      rq.instrument = 2'($urandom_range(0, 3));
      rq.limit_price = 32'd100 + $urandom_range(0, 8) - 4;
      rq.quantity = $urandom_range(1, 12);
      if (pick < 42) rq.kind = KIND_BUY;
      else if (pick < 84) rq.kind = KIND_SELL;
      else begin
        rq.kind = KIND_CANCEL;
        if (live_ids.size() != 0 && pick < 96)
          rq.order_ref = live_ids[$urandom_range(0, live_ids.size() - 1)];
      end
      if (pick == 99) begin
        rq.kind = KIND_NONE;
        rq.limit_price = $urandom();
        rq.quantity = $urandom();
      end else if (pick == 98) begin
        rq.limit_price = $urandom();
        rq.quantity = $urandom();
      end
      if (n == 30) rx_quiet = 1'b1;
      if (n == 40) rx_quiet = 1'b0;
      send_request(rq, n < 30 || n >= 40);
      if (live_ids.size() > 64) void'(live_ids.pop_front());
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_BUY;
    in_ch.order_ref = '0;
    in_ch.instrument = '0;
    in_ch.limit_price = '0;
    in_ch.quantity = '0;
    for (int i = 0; i < Slots; i++) bk_valid[i] = 1'b0;
    seq_count = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    // Sender pauses until every result is in.
    wait_drained();
    test_book_full();
    test_backpressure();
    test_random();
    wait_drained();
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
